// ===== rtl/tbq_pkg.sv =====
// tbq_pkg: shared types, codes and constants for the token bucket queue shaper.
// No dependencies; imported by every module of the block.
package tbq_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd2;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] CAP_RESET  = 32'd1000;
  localparam logic [31:0] RATE_RESET = 32'd100;
  localparam int          MS_PER_S   = 1000;

  // x / 1000 == (x * RECIP_1000) >> 38, exact for any 32-bit x
  localparam logic [28:0] RECIP_1000 = 29'h10624DD3;
  localparam int          RECIP_SH   = 38;

  // stream payload widths
  localparam int IN_DATA_W  = 56;   // 16 + 8 + 32
  localparam int OUT_DATA_W = 120;  // 114 used, padded to bytes
  localparam int OCC_W      = 11;
  localparam int QI_W       = 3;

  // widths in the refill arithmetic
  localparam int EHI_W = 23;        // elapsed / 1000
  localparam int ELO_W = 10;        // elapsed % 1000
  localparam int ADD_W = 33;        // refill amount, saturated at 2^32
  localparam int QSEL_W = 6;        // covers the largest queue count

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_NO_TOKENS  = 3'd1,
    ST_QUEUE_FULL = 3'd2,
    ST_BYPASS     = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  // one classified item as it leaves the front end
  typedef struct packed {
    logic              is_deq;
    logic              bypass;   // block disabled when the item came in
    logic              refill;   // elapsed time nonzero
    logic [15:0]       size;
    logic [QSEL_W-1:0] qsel;
    logic [ADD_W-1:0]  add;      // tokens to add, saturated
  } work_t;

  typedef struct packed {
    logic [31:0] rate;
    logic [EHI_W-1:0] rdiv;      // rate / 1000
    logic [ELO_W-1:0] rrem;      // rate % 1000
  } rate_t;

  typedef struct packed {
    logic        en;
    logic [31:0] value;
  } cap_wr_t;

  typedef struct packed {
    logic             ok;
    status_t          status;
    logic [QI_W-1:0]  queue_index;
    logic [31:0]      tokens_left;
    logic [OCC_W-1:0] queue_occupancy;
    logic [31:0]      accepted_total;
    logic [31:0]      dropped_total;
  } result_t;

  function automatic logic [EHI_W-1:0] div1000(input logic [31:0] x);
    logic [60:0] prod;
    prod = 61'(x) * 61'(RECIP_1000);
    return prod[RECIP_SH +: EHI_W];
  endfunction

endpackage

// ===== rtl/token_bucket_queue_shaper_core.sv =====
// token_bucket_queue_shaper_core: top level; config registers, front end,
// item queue and back end. Depends on tbq_pkg, tbq_front, tbq_fifo, tbq_back.
//
//  port group | dir | tdata fields (low bit up)                    | tuser
//  in_        | in  | pkt_size[15:0] priority_req[23:16] now_ms[55:24] | req_type
//  out_       | out | ok status queue_index tokens_left queue_occupancy
//             |     |   accepted_total dropped_total (bits 0..113)   | -
//  cfg_       | in  | we, index, wdata (enable, capacity, rate)
//
// An item passes the back-end refill state, then the apply state (spend and queue update);
// the back end takes the next item only once the last is applied and the output is free.
// out_tvalid rises once an accepted item has passed the five refill arithmetic stages,
// the queue write, the refill state and the apply state that loads the output register.
// rst_n is synchronous, active low; no clearing pass is needed after reset.
// Input is taken while the output register waits; in_tready drops once
// FIFO_DEPTH items sit in the front pipeline and the item queue together.
module token_bucket_queue_shaper_core #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_LIMIT = 1024,
  parameter int FIFO_DEPTH  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pkt_size[15:0], priority_req[23:16], now_ms[55:24]
  input  logic [tbq_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // ok[0], status[3:1], queue_index[6:4], tokens_left[38:7],
  // queue_occupancy[49:39], accepted_total[81:50], dropped_total[113:82]
  output logic [tbq_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [tbq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tbq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tbq_pkg::*;

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic             enable_r;
  logic [31:0]      cap_r, rate_r;
  logic [EHI_W-1:0] rdiv_r;
  logic [ELO_W-1:0] rrem_r;
  logic [31:0]      rrem_full;
  logic             enable_eff;
  rate_t            rate;
  cap_wr_t          cap_wr;
  logic             push, pop, head_valid;
  work_t            push_data, head_data;
  logic [CNT_W-1:0] fifo_count;
  result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      cap_r    <= CAP_RESET;
      rate_r   <= RATE_RESET;
      rdiv_r   <= EHI_W'(RATE_RESET / MS_PER_S);
      rrem_r   <= ELO_W'(RATE_RESET % MS_PER_S);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE:   enable_r <= cfg_wdata[0];
          CFG_CAPACITY: cap_r    <= cfg_wdata;
          CFG_RATE:     rate_r   <= cfg_wdata;
          default:      ;
        endcase
      end
      // registered split of the rate into thousands and remainder
      rdiv_r <= div1000(rate_r);
      rrem_r <= rrem_full[ELO_W-1:0];
    end
  end

  assign rrem_full  = rate_r - 32'(rdiv_r) * 32'(MS_PER_S);
  assign enable_eff = (cfg_we && (cfg_index == CFG_ENABLE)) ? cfg_wdata[0] : enable_r;
  assign rate.rate  = rate_r;
  assign rate.rdiv  = rdiv_r;
  assign rate.rrem  = rrem_r;
  assign cap_wr.en    = cfg_we && (cfg_index == CFG_CAPACITY);
  assign cap_wr.value = cfg_wdata;

  tbq_front #(
    .NUM_QUEUES (NUM_QUEUES),
    .FIFO_DEPTH (FIFO_DEPTH),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .enable     (enable_eff),
    .rate       (rate),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  tbq_fifo #(
    .DEPTH (FIFO_DEPTH),
    .CNT_W (CNT_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (fifo_count)
  );

  tbq_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_LIMIT (QUEUE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .cap        (cap_r),
    .cap_wr     (cap_wr),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (res)
  );

  assign out_tdata = {6'b0, res.dropped_total, res.accepted_total, res.queue_occupancy,
                      res.tokens_left, res.queue_index, res.status, res.ok};

endmodule

// ===== rtl/tbq_front.sv =====
// tbq_front: accepts items, classifies them and computes the refill amount
// in a five-stage pipeline. Depends on tbq_pkg.
module tbq_front #(
  parameter int NUM_QUEUES = 8,
  parameter int FIFO_DEPTH = 8,
  parameter int CNT_W      = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic                    in_tuser,
  input  logic [tbq_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                    enable,
  input  tbq_pkg::rate_t          rate,
  input  logic [CNT_W-1:0]        fifo_count,
  output logic                    push,
  output tbq_pkg::work_t          push_data
);
  import tbq_pkg::*;

  localparam int P1_W = 32 + EHI_W;
  localparam int P2_W = 32;
  localparam int P3_W = 20;
  localparam int SUM_W = 56;
  // ceil(2^16 / NUM_QUEUES); exact quotient for any 8-bit priority
  localparam int QREC = (65536 + NUM_QUEUES - 1) / NUM_QUEUES;

  logic        accept;
  logic [15:0] size;
  logic [7:0]  prio;
  logic [31:0] now_ms;
  logic [31:0] last_ms_r;
  logic [7:0]  qrem;
  logic [24:0] qprod;
  logic [7:0]  qquot;
  logic [15:0] qback;
  logic [2:0]  pipe_cnt;

  work_t            it0_r, it1_r, it2_r, it3_r, it4_r;
  logic             v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [31:0]      el0_r, el1_r;
  logic [EHI_W-1:0] ehi1_r;
  logic [ELO_W-1:0] elo2_r;
  logic [P1_W-1:0]  p1_2_r, p1_3_r;
  logic [P2_W-1:0]  p2_3_r;
  logic [P3_W-1:0]  p3_3_r;
  logic [SUM_W-1:0] s4_r;
  logic [ELO_W-1:0] p3q4_r;
  logic [31:0]      elo_full;
  logic [48:0]      p3_prod;
  logic [SUM_W-1:0] add_full;

  assign size   = in_tdata[15:0];
  assign prio   = in_tdata[23:16];
  assign now_ms = in_tdata[55:24];

  assign pipe_cnt  = 3'(v0_r) + 3'(v1_r) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r);
  // credit: everything in flight must fit in the queue
  assign in_tready = (32'(fifo_count) + 32'(pipe_cnt)) < 32'(FIFO_DEPTH);
  assign accept    = in_tvalid & in_tready;

  // priority mod NUM_QUEUES by reciprocal multiply, then multiply back
  assign qprod = 25'(prio) * 25'(QREC);
  assign qquot = qprod[16 +: 8];
  assign qback = 16'(qquot) * 16'(NUM_QUEUES);
  assign qrem  = prio - qback[7:0];

  assign elo_full = el1_r - 32'(ehi1_r) * 32'(MS_PER_S);
  assign p3_prod  = 49'(p3_3_r) * 49'(RECIP_1000);
  assign add_full = s4_r + SUM_W'(p3q4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      last_ms_r <= '0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      // after any enabled enqueue arrival the bucket's refill time equals its timestamp
      if (accept && enable && !in_tuser) begin
        last_ms_r <= now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    it0_r.is_deq <= in_tuser;
    it0_r.bypass <= ~enable;
    it0_r.refill <= (now_ms != last_ms_r);
    it0_r.size   <= size;
    it0_r.qsel   <= QSEL_W'(qrem);
    it0_r.add    <= '0;
    el0_r        <= now_ms - last_ms_r;

    it1_r  <= it0_r;
    el1_r  <= el0_r;
    ehi1_r <= div1000(el0_r);

    it2_r  <= it1_r;
    elo2_r <= elo_full[ELO_W-1:0];
    p1_2_r <= P1_W'(rate.rate) * P1_W'(ehi1_r);

    it3_r  <= it2_r;
    p1_3_r <= p1_2_r;
    p2_3_r <= P2_W'(rate.rdiv) * P2_W'(elo2_r);
    p3_3_r <= P3_W'(rate.rrem) * P3_W'(elo2_r);

    it4_r  <= it3_r;
    s4_r   <= SUM_W'(p1_3_r) + SUM_W'(p2_3_r);
    p3q4_r <= p3_prod[RECIP_SH +: ELO_W];
  end

  assign push = v4_r;
  always_comb begin
    push_data     = it4_r;
    push_data.add = (|add_full[SUM_W-1:32]) ? {1'b1, 32'h0} : {1'b0, add_full[31:0]};
  end

`ifndef NO_ASSERTIONS
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(fifo_count) + 32'(pipe_cnt)) <= 32'(FIFO_DEPTH))
    else $error("front: items in flight exceed queue depth");
`endif

endmodule

// ===== rtl/tbq_fifo.sv =====
// tbq_fifo: short queue of classified items between front and back end.
// Depends on tbq_pkg for the item type.
module tbq_fifo #(
  parameter int DEPTH = 8,
  parameter int CNT_W = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tbq_pkg::work_t     push_data,
  input  logic               pop,
  output logic               head_valid,
  output tbq_pkg::work_t     head_data,
  output logic [CNT_W-1:0]   count
);
  import tbq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  work_t            mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign count      = count_r;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && (count_r == CNT_W'(DEPTH))))
    else $error("fifo: push into a full queue");
`endif

endmodule

// ===== rtl/tbq_back.sv =====
// tbq_back: carries out items: bucket refill, spend, queue counters and results.
// Each item passes a refill state, then an apply state; depends on tbq_pkg.
module tbq_back #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_LIMIT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  tbq_pkg::work_t     head_data,
  output logic               pop,
  input  logic [31:0]        cap,
  input  tbq_pkg::cap_wr_t   cap_wr,
  output logic               out_valid,
  input  logic               out_ready,
  output tbq_pkg::result_t   out_result
);
  import tbq_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW = $clog2(QUEUE_LIMIT + 1);

  typedef struct packed {
    logic [CW-1:0] pkts;
    logic [31:0]   bytes;
  } qent_t;

  typedef enum logic {B_REFILL, B_APPLY} bstate_t;

  bstate_t         st_r;
  qent_t           qmem [NUM_QUEUES];
  qent_t           rd_ent_r;
  logic            rd_vld_r;
  logic [NUM_QUEUES-1:0] qvalid_r, nonempty_r;
  logic [QW-1:0]   cur_q_r, first_q, rd_addr;
  logic            none_r;
  logic [31:0]     token_r, token_nxt;
  logic [31:0]     acc_pkts_r, drop_pkts_r;
  logic [47:0]     acc_bytes_r, drop_bytes_r;
  result_t         out_r, res_nxt;
  logic            out_valid_r;
  logic            can_out;
  logic [33:0]     sum;
  logic [31:0]     refilled;
  logic [CW-1:0]   cnt;
  logic [31:0]     bytes;
  logic            mem_we, set_ne, clr_ne, acc_inc, drop_inc;
  qent_t           mem_wdata;

  // lowest-numbered nonempty queue
  always_comb begin
    first_q = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (nonempty_r[i]) begin
        first_q = QW'(i);
      end
    end
  end

  assign rd_addr  = head_data.is_deq ? first_q : head_data.qsel[QW-1:0];
  assign sum      = {2'b0, token_r} + {1'b0, head_data.add};
  assign refilled = (sum > {2'b0, cap}) ? cap : sum[31:0];
  assign can_out  = !out_valid_r || out_ready;
  assign pop      = (st_r == B_APPLY) && can_out;

  assign cnt   = rd_vld_r ? rd_ent_r.pkts : '0;
  assign bytes = rd_vld_r ? rd_ent_r.bytes : '0;

  always_comb begin
    token_nxt = token_r;
    mem_we    = 1'b0;
    mem_wdata = rd_ent_r;
    set_ne    = 1'b0;
    clr_ne    = 1'b0;
    acc_inc   = 1'b0;
    drop_inc  = 1'b0;
    res_nxt.ok              = 1'b0;
    res_nxt.status          = ST_DONE;
    res_nxt.queue_index     = '0;
    res_nxt.queue_occupancy = '0;
    priority if (head_data.bypass) begin
      res_nxt.ok     = ~head_data.is_deq;
      res_nxt.status = ST_BYPASS;
    end else if (head_data.is_deq) begin
      if (none_r) begin
        res_nxt.status = ST_EMPTY;
      end else begin
        mem_we          = 1'b1;
        mem_wdata.pkts  = cnt - CW'(1);
        mem_wdata.bytes = (bytes > 32'(head_data.size)) ? bytes - 32'(head_data.size) : '0;
        clr_ne          = (cnt == CW'(1));
        res_nxt.ok              = 1'b1;
        res_nxt.queue_index     = QI_W'(cur_q_r);
        res_nxt.queue_occupancy = OCC_W'(mem_wdata.pkts);
      end
    end else if (token_r < 32'(head_data.size)) begin
      drop_inc       = 1'b1;
      res_nxt.status = ST_NO_TOKENS;
    end else begin
      // tokens stay spent even on a tail drop
      token_nxt = token_r - 32'(head_data.size);
      res_nxt.queue_index = QI_W'(cur_q_r);
      if (cnt >= CW'(QUEUE_LIMIT)) begin
        drop_inc                = 1'b1;
        res_nxt.status          = ST_QUEUE_FULL;
        res_nxt.queue_occupancy = OCC_W'(cnt);
      end else begin
        mem_we          = 1'b1;
        mem_wdata.pkts  = cnt + CW'(1);
        mem_wdata.bytes = (bytes > 32'hFFFF_FFFF - 32'(head_data.size)) ?
                          32'hFFFF_FFFF : bytes + 32'(head_data.size);
        set_ne          = 1'b1;
        acc_inc         = 1'b1;
        res_nxt.ok              = 1'b1;
        res_nxt.queue_occupancy = OCC_W'(mem_wdata.pkts);
      end
    end
    res_nxt.tokens_left    = token_nxt;
    res_nxt.accepted_total = acc_pkts_r + 32'(acc_inc);
    res_nxt.dropped_total  = drop_pkts_r + 32'(drop_inc);
  end

  always_ff @(posedge clk) begin
    if ((st_r == B_APPLY) && can_out && mem_we) begin
      qmem[cur_q_r] <= mem_wdata;
    end
    if ((st_r == B_REFILL) && head_valid) begin
      rd_ent_r <= qmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= B_REFILL;
      token_r      <= CAP_RESET;
      qvalid_r     <= '0;
      nonempty_r   <= '0;
      acc_pkts_r   <= '0;
      drop_pkts_r  <= '0;
      acc_bytes_r  <= '0;
      drop_bytes_r <= '0;
      out_valid_r  <= 1'b0;
      rd_vld_r     <= 1'b0;
      cur_q_r      <= '0;
      none_r       <= 1'b1;
    end else begin
      if (out_valid_r && out_ready && !pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        B_REFILL: begin
          if (head_valid) begin
            rd_vld_r <= qvalid_r[rd_addr];
            cur_q_r  <= rd_addr;
            none_r   <= ~|nonempty_r;
            if (!head_data.bypass && !head_data.is_deq && head_data.refill) begin
              token_r <= refilled;
            end
            st_r <= B_APPLY;
          end
        end
        B_APPLY: begin
          if (can_out) begin
            token_r     <= token_nxt;
            out_r       <= res_nxt;
            out_valid_r <= 1'b1;
            if (mem_we) begin
              qvalid_r[cur_q_r] <= 1'b1;
            end
            if (set_ne) begin
              nonempty_r[cur_q_r] <= 1'b1;
            end
            if (clr_ne) begin
              nonempty_r[cur_q_r] <= 1'b0;
            end
            if (acc_inc) begin
              acc_pkts_r  <= acc_pkts_r + 32'd1;
              acc_bytes_r <= acc_bytes_r + 48'(head_data.size);
            end
            if (drop_inc) begin
              drop_pkts_r  <= drop_pkts_r + 32'd1;
              drop_bytes_r <= drop_bytes_r + 48'(head_data.size);
            end
            st_r <= B_REFILL;
          end
        end
        default: st_r <= B_REFILL;
      endcase
      // a capacity write clamps the bucket; the user writes it only while idle, not enforced here
      if (cap_wr.en && (token_r > cap_wr.value)) begin
        token_r <= cap_wr.value;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

`ifndef NO_ASSERTIONS
  a_token_cap: assert property (@(posedge clk) disable iff (!rst_n)
    token_r <= cap)
    else $error("back: token count above capacity");
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_APPLY) |-> head_valid)
    else $error("back: queue head lost while an item is applied");
`endif

endmodule
